### sv/dsp_pkg.sv
// Shared types and constants for the shortest-path unit.
package dsp_pkg;

  // Distance width and the saturated "infinite" cost
  localparam int             COST_BITS = 24;
  localparam logic [23:0]    COST_MAX  = 24'hFFFFFF;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Input beat: one matrix write or one run request
  typedef struct packed {
    logic        opcode;
    logic [2:0]  from_vertex;
    logic [2:0]  to_vertex;
    logic [15:0] edge_weight;
    logic [2:0]  source_vertex;
  } in_beat_t;

  // Result beat: one per vertex
  typedef struct packed {
    logic [2:0]  vertex_index;
    logic [23:0] path_cost;
    logic [2:0]  predecessor;
    logic        has_predecessor;
    logic        reachable;
    logic        last;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_we;      // clearing pass: zero one matrix entry
    logic load_we;     // write one edge weight
    logic run_start;   // init flags, source distance
    logic scan_first;  // first read of a min scan, drop old best
    logic scan_rd;     // read distance for min scan
    logic pick;        // retire best vertex from the queue
    logic relax_rd;    // read edge and head distance for relaxation
    logic out_rd;      // read distance and predecessor for a result
    logic out_load;    // load the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic best_found;  // min scan found an unvisited reached vertex
    logic out_busy;    // output register holds a beat not yet taken
  } dp_status_t;

endpackage

### sv/dijkstra_shortest_paths_unit.sv
// Load beat: written to the matrix on acceptance. Run beat: each reached vertex costs a min scan
// over all NODES distances and a relaxation pass over its matrix row, then one final scan,
// then one result beat per vertex, each waiting while the output register is still busy.
// The run time is set by the single-read distance memory and the one-edge-a-cycle matrix read.
// After reset a clearing pass zeroes all NODES*NODES matrix entries with in_ready low.
// A finished result waits in the output register while the next load beat is taken.
module dijkstra_shortest_paths_unit #(
  parameter int NODES       = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsp_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output dsp_pkg::out_beat_t out_beat
);
  import dsp_pkg::*;

  localparam int AW = $clog2(NODES*NODES);

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [AW-1:0] idx;

  dsp_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_beat.opcode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .idx      (idx)
  );

  dsp_datapath #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idx       (idx),
    .in_beat   (in_beat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .status    (status)
  );

  // A result beat is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result loaded over a pending beat");

  // No input beat is taken while the matrix is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_we |-> !in_ready)
    else $error("input ready during clearing pass");

  // No search or output read runs while inputs are being taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.scan_rd || cmd.relax_rd || cmd.out_rd))
    else $error("search activity while ready for input");

  // Retiring a vertex is followed by its relaxation pass
  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |=> !status.best_found || cmd.relax_rd)
    else $error("relaxation did not follow a pick");

endmodule

### sv/dsp_ctrl.sv
// Sequencer for clearing, loads, min scans, relaxation and result output.
module dsp_ctrl #(
  parameter int NODES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_op,
  output logic                                in_ready,
  input  dsp_pkg::dp_status_t                 status,
  output dsp_pkg::ctrl_cmd_t                  cmd,
  output logic [$clog2(NODES*NODES)-1:0]      idx
);
  import dsp_pkg::*;

  localparam int AW = $clog2(NODES*NODES);
  localparam int VW = $clog2(NODES);
  localparam logic [AW-1:0] CLR_LAST = AW'(NODES*NODES-1);
  localparam logic [VW-1:0] VTX_LAST = VW'(NODES-1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SCEND = 4'd3;
  localparam logic [3:0] S_PICK  = 4'd4;
  localparam logic [3:0] S_RELAX = 4'd5;
  localparam logic [3:0] S_RLEND = 4'd6;
  localparam logic [3:0] S_ORD   = 4'd7;
  localparam logic [3:0] S_OLD   = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          vtx_last;

  assign vtx_last = (idx_r[VW-1:0] == VTX_LAST);
  assign idx      = idx_r;
  assign in_ready = (state_r == S_IDLE);

  // Next state, counter and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_we = 1'b1;
        if (idx_r == CLR_LAST) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_RUN) begin
            cmd.run_start = 1'b1;
            state_nxt     = S_SCAN;
            idx_nxt       = '0;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd    = 1'b1;
        cmd.scan_first = (idx_r == '0);
        if (vtx_last) begin
          state_nxt = S_SCEND;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_SCEND: state_nxt = S_PICK;
      S_PICK: begin
        idx_nxt = '0;
        if (status.best_found) begin
          cmd.pick  = 1'b1;
          state_nxt = S_RELAX;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_RELAX: begin
        cmd.relax_rd = 1'b1;
        if (vtx_last) begin
          state_nxt = S_RLEND;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_RLEND: state_nxt = S_SCAN;
      S_ORD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OLD;
      end
      S_OLD: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          if (vtx_last) begin
            state_nxt = S_IDLE;
            idx_nxt   = '0;
          end else begin
            state_nxt = S_ORD;
            idx_nxt   = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### sv/dsp_datapath.sv
// Weight matrix, distance and predecessor memories, min scan and relaxation.
module dsp_datapath #(
  parameter int NODES       = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dsp_pkg::ctrl_cmd_t              cmd,
  input  logic [$clog2(NODES*NODES)-1:0]  idx,
  input  dsp_pkg::in_beat_t               in_beat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output dsp_pkg::out_beat_t              out_beat,
  output dsp_pkg::dp_status_t             status
);
  import dsp_pkg::*;

  localparam int AW = $clog2(NODES*NODES);
  localparam int VW = $clog2(NODES);
  localparam int SW = ((WEIGHT_BITS > COST_BITS) ? WEIGHT_BITS : COST_BITS) + 1;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(NODES);
  localparam logic [VW-1:0] VTX_LAST   = VW'(NODES-1);

  // Memories
  logic [WEIGHT_BITS-1:0] wmem [NODES*NODES];
  logic [COST_BITS-1:0]   dmem [NODES];
  logic [VW-1:0]          pmem [NODES];
  logic [WEIGHT_BITS-1:0] wt_q;
  logic [COST_BITS-1:0]   dist_q;
  logic [VW-1:0]          pred_q;

  // Per-vertex flags and pipeline control
  logic [NODES-1:0] seen_r, seen_nxt;
  logic [NODES-1:0] inq_r, inq_nxt;
  logic [NODES-1:0] pv_r, pv_nxt;
  logic             scan_v_r, relax_v_r;
  logic             best_valid_r, best_valid_nxt;
  logic [VW-1:0]    best_idx_r, best_idx_nxt;
  logic [COST_BITS-1:0] best_dist_r, best_dist_nxt;
  logic [VW-1:0]    vtx_d_r;
  logic             out_valid_r;
  out_beat_t        out_beat_r;

  logic [VW-1:0]    vtx;
  logic             load_ok, src_ok;
  logic [VW-1:0]    src_v;
  logic [AW-1:0]    load_addr, relax_addr;
  logic [SW-1:0]    sum;
  logic [COST_BITS-1:0] cand;
  logic             upd, take;

  assign vtx        = idx[VW-1:0];
  assign load_ok    = (32'(in_beat.from_vertex) < NODES) && (32'(in_beat.to_vertex) < NODES);
  assign src_ok     = (32'(in_beat.source_vertex) < NODES);
  assign src_v      = VW'(in_beat.source_vertex);
  assign load_addr  = AW'(VW'(in_beat.from_vertex)) * ROW_STRIDE
                    + AW'(VW'(in_beat.to_vertex));
  assign relax_addr = AW'(best_idx_r) * ROW_STRIDE + AW'(vtx);

  // Weight matrix: clear or load write, relaxation read
  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      wmem[idx] <= '0;
    end else if (cmd.load_we && load_ok) begin
      wmem[load_addr] <= WEIGHT_BITS'(in_beat.edge_weight);
    end
    if (cmd.relax_rd) begin
      wt_q <= wmem[relax_addr];
    end
  end

  // Relaxation stage: saturating candidate and strict-less update
  assign sum  = SW'(best_dist_r) + SW'(wt_q);
  assign cand = (sum > SW'(COST_MAX)) ? COST_MAX : sum[COST_BITS-1:0];
  assign upd  = relax_v_r && (wt_q != '0) && (!seen_r[vtx_d_r] || (dist_q > cand));

  // Min scan stage: lowest index wins ties
  assign take = scan_v_r && inq_r[vtx_d_r] && seen_r[vtx_d_r]
             && (!best_valid_r || (dist_q < best_dist_r));

  // Distance and predecessor memories
  always_ff @(posedge clk) begin
    if (cmd.run_start && src_ok) begin
      dmem[src_v] <= '0;
    end else if (upd) begin
      dmem[vtx_d_r] <= cand;
    end
    if (cmd.scan_rd || cmd.relax_rd || cmd.out_rd) begin
      dist_q <= dmem[vtx];
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      pmem[vtx_d_r] <= best_idx_r;
    end
    if (cmd.out_rd) begin
      pred_q <= pmem[vtx];
    end
  end

  // Flag and best-vertex updates
  always_comb begin
    seen_nxt       = seen_r;
    inq_nxt        = inq_r;
    pv_nxt         = pv_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    best_dist_nxt  = best_dist_r;
    if (cmd.run_start) begin
      seen_nxt = '0;
      inq_nxt  = '1;
      pv_nxt   = '0;
      if (src_ok) begin
        seen_nxt[src_v] = 1'b1;
      end
    end
    if (upd) begin
      seen_nxt[vtx_d_r] = 1'b1;
      pv_nxt[vtx_d_r]   = 1'b1;
    end
    if (cmd.pick) begin
      inq_nxt[best_idx_r] = 1'b0;
    end
    if (cmd.scan_first) begin
      best_valid_nxt = 1'b0;
    end
    if (take) begin
      best_valid_nxt = 1'b1;
      best_idx_nxt   = vtx_d_r;
      best_dist_nxt  = dist_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      inq_r        <= '0;
      pv_r         <= '0;
      best_valid_r <= 1'b0;
      scan_v_r     <= 1'b0;
      relax_v_r    <= 1'b0;
    end else begin
      seen_r       <= seen_nxt;
      inq_r        <= inq_nxt;
      pv_r         <= pv_nxt;
      best_valid_r <= best_valid_nxt;
      scan_v_r     <= cmd.scan_rd;
      relax_v_r    <= cmd.relax_rd;
    end
  end

  always_ff @(posedge clk) begin
    vtx_d_r     <= vtx;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beat_r.vertex_index    <= 3'(vtx_d_r);
      out_beat_r.path_cost       <= seen_r[vtx_d_r] ? dist_q : COST_MAX;
      out_beat_r.predecessor     <= pv_r[vtx_d_r] ? 3'(pred_q) : 3'd0;
      out_beat_r.has_predecessor <= pv_r[vtx_d_r];
      out_beat_r.reachable       <= seen_r[vtx_d_r];
      out_beat_r.last            <= (vtx_d_r == VTX_LAST);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_beat          = out_beat_r;
  assign status.best_found = best_valid_r;
  assign status.out_busy   = out_valid_r && !out_ready;

endmodule

### test/dsp_path_checker.sv
// Checker for the shortest-path unit: predicts result beats and compares them.
module dsp_path_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dsp_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dsp_pkg::out_beat_t out_beat,
  output int                 mismatches,
  output int                 pending
);
  import dsp_pkg::*;

  localparam int NODES = 8;

  // Shadow adjacency matrix, 0 = no edge
  logic [15:0] edge_w [NODES][NODES];
  // Result beats still owed by the unit, oldest first
  out_beat_t   owed_results [$];
  out_beat_t   want;

  // One line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] exp_val);
    $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Dijkstra over the shadow matrix; queues one result beat per vertex
  function automatic void predict_paths(input logic [2:0] src);
    bit          queued   [NODES];
    bit          seen     [NODES];
    logic [23:0] cost     [NODES];
    logic [2:0]  prev     [NODES];
    bit          has_prev [NODES];
    int          best;
    logic [24:0] sum;
    logic [23:0] cand;
    out_beat_t   r;
    for (int i = 0; i < NODES; i++) begin
      queued[i]   = 1'b1;
      seen[i]     = 1'b0;
      cost[i]     = COST_MAX;
      prev[i]     = 3'd0;
      has_prev[i] = 1'b0;
    end
    cost[src] = 24'd0;
    seen[src] = 1'b1;
    for (int k = 0; k < NODES; k++) begin
      // least reached unvisited vertex, lowest index on ties
      best = -1;
      for (int i = 0; i < NODES; i++) begin
        if (queued[i] && seen[i] && (best < 0 || cost[i] < cost[best]))
          best = i;
      end
      if (best < 0)
        break;
      queued[best] = 1'b0;
      // relax outgoing edges, strict-less, saturating sum
      for (int w = 0; w < NODES; w++) begin
        if (edge_w[best][w] != 16'd0) begin
          sum  = {1'b0, cost[best]} + {9'd0, edge_w[best][w]};
          cand = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[23:0];
          if (!seen[w] || cost[w] > cand) begin
            cost[w]     = cand;
            prev[w]     = 3'(best);
            has_prev[w] = 1'b1;
            seen[w]     = 1'b1;
          end
        end
      end
    end
    for (int v = 0; v < NODES; v++) begin
      r.vertex_index    = 3'(v);
      r.reachable       = has_prev[v] || (3'(v) == src);
      r.path_cost       = r.reachable ? cost[v] : COST_MAX;
      r.predecessor     = has_prev[v] ? prev[v] : 3'd0;
      r.has_predecessor = has_prev[v];
      r.last            = (v == NODES - 1);
      owed_results.push_back(r);
    end
  endfunction

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++)
        for (int j = 0; j < NODES; j++)
          edge_w[i][j] = 16'd0;
      owed_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_beat.opcode == OP_LOAD)
          edge_w[in_beat.from_vertex][in_beat.to_vertex] = in_beat.edge_weight;
        else
          predict_paths(in_beat.source_vertex);
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result beat with none owed, vertex_index",
                          24'(out_beat.vertex_index), 24'd0);
        end else begin
          want = owed_results.pop_front();
          if (out_beat.vertex_index !== want.vertex_index)
            report_mismatch("vertex_index", 24'(out_beat.vertex_index),
                            24'(want.vertex_index));
          if (out_beat.path_cost !== want.path_cost)
            report_mismatch("path_cost", out_beat.path_cost, want.path_cost);
          if (out_beat.predecessor !== want.predecessor)
            report_mismatch("predecessor", 24'(out_beat.predecessor),
                            24'(want.predecessor));
          if (out_beat.has_predecessor !== want.has_predecessor)
            report_mismatch("has_predecessor", 24'(out_beat.has_predecessor),
                            24'(want.has_predecessor));
          if (out_beat.reachable !== want.reachable)
            report_mismatch("reachable", 24'(out_beat.reachable),
                            24'(want.reachable));
          if (out_beat.last !== want.last)
            report_mismatch("last", 24'(out_beat.last), 24'(want.last));
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

### test/testbench.sv
// Testbench top: stimulus, flow control and verdict for the shortest-path unit.
module testbench;
  import dsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 250;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 480;
  localparam int PHASES         = 4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int sent           = 0;

  dijkstra_shortest_paths_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  dsp_path_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one beat after optional idle cycles; return once it is taken
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sent++;
  endtask

  // Edge write; the unused source field carries noise
  function automatic in_beat_t load_beat(input logic [2:0] tail, input logic [2:0] head,
                                         input logic [15:0] w);
    in_beat_t b;
    b.opcode        = OP_LOAD;
    b.from_vertex   = tail;
    b.to_vertex     = head;
    b.edge_weight   = w;
    b.source_vertex = 3'($urandom);
    return b;
  endfunction

  // Run request; the unused edge fields carry noise
  function automatic in_beat_t run_beat(input logic [2:0] src);
    in_beat_t b;
    b.opcode        = OP_RUN;
    b.from_vertex   = 3'($urandom);
    b.to_vertex     = 3'($urandom);
    b.edge_weight   = 16'($urandom);
    b.source_vertex = src;
    return b;
  endfunction

  // Weights: many deletions, small values for ties, values near the top
  function automatic logic [15:0] rand_weight();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20)
      return 16'd0;
    if (roll < 55)
      return 16'($urandom_range(1, 4));
    if (roll < 65)
      return 16'hFFFF - 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  // Stimulus and verdict
  initial begin
    int          phase_end;
    int          roll;
    logic [2:0]  row;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty graph, a tie, a self loop, heavy edges, deletions
    send_beat(run_beat(3'd0));
    send_beat(load_beat(3'd0, 3'd1, 16'd2));
    send_beat(load_beat(3'd0, 3'd2, 16'd1));
    send_beat(load_beat(3'd2, 3'd1, 16'd1));
    send_beat(load_beat(3'd3, 3'd3, 16'd5));
    send_beat(load_beat(3'd1, 3'd3, 16'hFFFF));
    send_beat(load_beat(3'd3, 3'd7, 16'hFFFF));
    send_beat(load_beat(3'd7, 3'd0, 16'h8000));
    send_beat(in_beat_t'{OP_RUN, 3'd7, 3'd7, 16'hFFFF, 3'd0});
    send_beat(run_beat(3'd7));
    send_beat(run_beat(3'd3));
    send_beat(in_beat_t'{OP_LOAD, 3'd0, 3'd2, 16'd0, 3'd7});
    send_beat(run_beat(3'd0));
    send_beat(load_beat(3'd5, 3'd6, 16'd0));
    send_beat(run_beat(3'd5));
    send_beat(load_beat(3'd6, 3'd4, 16'd1));
    send_beat(load_beat(3'd4, 3'd6, 16'd1));
    send_beat(run_beat(3'd6));

    // Random: build-then-run sequences, row wipes and raw noise beats
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_requests <= hold_requests + 1;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      phase_end = sent + RANDOM_ITEMS / PHASES;
      while (sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          repeat ($urandom_range(1, 10))
            send_beat(load_beat(3'($urandom), 3'($urandom), rand_weight()));
          repeat ($urandom_range(1, 2))
            send_beat(run_beat(3'($urandom)));
        end else if (roll < 88) begin
          // wipe one row, leaving its vertex with no way out
          row = 3'($urandom);
          for (int j = 0; j < 8; j++)
            send_beat(load_beat(row, 3'(j), 16'd0));
          send_beat(run_beat($urandom_range(1) ? row : 3'($urandom)));
        end else begin
          repeat ($urandom_range(1, 3))
            send_beat(in_beat_t'(26'($urandom)));
        end
      end
    end
    in_valid <= 1'b0;

    // Drain owed results, then a quiet margin
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
